// ----- hdl/mcftm_pkg.sv -----
// Package for the multi-channel frame timestamp matcher.
// Shared types, request codes, limits and controller/datapath command structs.
`default_nettype none
package mcftm_pkg;

    localparam int CHANNELS_DEF    = 4;
    localparam int HISTORY_MAX_DEF = 16;

    localparam int TS_W   = 48;
    localparam int CNT_W  = 32;
    localparam int MEAN_W = 64;
    localparam int DEPTH_W = 5;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 48;

    localparam logic [CNT_W-1:0] SAT32 = '1;

    typedef enum logic [1:0] {
        REQ_PUSH_IR  = 2'd0,
        REQ_PUSH_REF = 2'd1,
        REQ_SET_LINK = 2'd2,
        REQ_MATCH    = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        CFG_HISTORY_DEPTH   = 2'd0,
        CFG_STALE_TIMEOUT   = 2'd1,
        CFG_MATCH_TOLERANCE = 2'd2
    } cfg_idx_t;

    // Controller -> datapath commands
    typedef struct packed {
        logic do_push;      // write stamp and update channel state
        logic do_ref;       // record reference receive time
        logic do_link;      // update link flag
        logic ch_load;      // start of channel evaluation: latch status
        logic scan_rd;      // issue history read for current scan index
        logic scan_cmp;     // compare returned stamp against best
        logic upd;          // update counters, start mean division
        logic div_step;     // one restoring division step
        logic commit;       // write mean, drive result strobe
    } dp_cmd_t;

    // Datapath -> controller status
    typedef struct packed {
        logic active;       // current channel is connected with stamps
        logic used;         // best match within tolerance
        logic scan_last;    // current scan index is the last stored stamp
        logic div_last;     // final division step
    } dp_stat_t;

endpackage : mcftm_pkg
`default_nettype wire

// ----- hdl/mcftm_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none
module mcftm_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule : mcftm_ram
`default_nettype wire

// ----- hdl/mcftm_ctrl.sv -----
// Controller state machine for the timestamp matcher.
// Depends on mcftm_pkg; sequences the datapath through commands and status.
`default_nettype none
module mcftm_ctrl
    import mcftm_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    input  wire logic [1:0] req_type,
    output logic          busy,
    output dp_cmd_t       cmd,
    input  wire dp_stat_t stat,
    output logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] ch_idx,
    output logic          last_ch
);
    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_LOAD  = 8'b0000_0010,
        S_READ  = 8'b0000_0100,
        S_CMP   = 8'b0000_1000,
        S_UPD   = 8'b0001_0000,
        S_DIV   = 8'b0010_0000,
        S_EMIT  = 8'b0100_0000,
        S_NEXT  = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic [CH_W-1:0] ch_reg, ch_next;

    assign busy    = (state_reg != S_IDLE);
    assign ch_idx  = ch_reg;
    assign last_ch = (32'(ch_reg) == CHANNELS - 1);

    always_comb
    begin
        state_next = state_reg;
        ch_next    = ch_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (req_type)
                        REQ_PUSH_IR:  cmd.do_push = 1'b1;
                        REQ_PUSH_REF: cmd.do_ref  = 1'b1;
                        REQ_SET_LINK: cmd.do_link = 1'b1;
                        default:
                        begin
                            ch_next    = '0;
                            state_next = S_LOAD;
                        end
                    endcase
                end
            end
            S_LOAD:
            begin
                cmd.ch_load = 1'b1;
                state_next  = S_READ;
            end
            S_READ:
            begin
                if (stat.active)
                begin
                    cmd.scan_rd = 1'b1;
                    state_next  = S_CMP;
                end
                else
                begin
                    state_next = S_UPD;
                end
            end
            S_CMP:
            begin
                cmd.scan_cmp = 1'b1;
                state_next   = stat.scan_last ? S_UPD : S_READ;
            end
            S_UPD:
            begin
                cmd.upd    = 1'b1;
                state_next = (stat.active && stat.used) ? S_DIV : S_EMIT;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                cmd.commit = 1'b1;
                state_next = last_ch ? S_IDLE : S_NEXT;
            end
            S_NEXT:
            begin
                ch_next    = ch_reg + 1'b1;
                state_next = S_LOAD;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ch_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ch_reg    <= ch_next;
        end
    end

    a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_reg))
        else $error("state not one-hot");
    a_commit_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit && last_ch |=> state_reg == S_IDLE)
        else $error("no return to idle after last channel");
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && req_type == REQ_MATCH |=> state_reg == S_LOAD)
        else $error("match not started");
endmodule : mcftm_ctrl
`default_nettype wire

// ----- hdl/mcftm_dp.sv -----
// Datapath for the timestamp matcher: channel state, history RAM, nearest
// search, counters and a serial divider for the running mean. Uses mcftm_pkg.
`default_nettype none
module mcftm_dp
    import mcftm_pkg::*;
#(
    parameter int CHANNELS    = CHANNELS_DEF,
    parameter int HISTORY_MAX = HISTORY_MAX_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire dp_cmd_t           cmd,
    output dp_stat_t               stat,
    input  wire logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] ch_idx,
    input  wire logic              last_ch,
    // request fields, sampled at accept
    input  wire logic              start,
    input  wire logic [3:0]        channel,
    input  wire logic [TS_W-1:0]   frame_timestamp,
    input  wire logic [TS_W-1:0]   now_time,
    input  wire logic              link_state,
    // configuration
    input  wire logic [DEPTH_W-1:0] cfg_depth,
    input  wire logic [TS_W-1:0]   cfg_stale,
    input  wire logic [TS_W-1:0]   cfg_tol,
    // results
    output logic                   result_valid,
    output logic [3:0]             out_channel,
    output logic                   channel_active,
    output logic                   match_used,
    output logic signed [TS_W:0]   time_delta,
    output logic [TS_W-1:0]        chosen_stamp,
    output logic [CNT_W-1:0]       matched_count,
    output logic [CNT_W-1:0]       disconnected_count,
    output logic [CNT_W-1:0]       out_of_tolerance_count,
    output logic [TS_W-1:0]        largest_abs_delta,
    output logic [MEAN_W-1:0]      mean_abs_delta,
    output logic                   reference_connected,
    output logic                   last_result
);
    localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SLOT_W = (HISTORY_MAX > 1) ? $clog2(HISTORY_MAX) : 1;
    localparam int FILL_W = $clog2(HISTORY_MAX + 1);
    localparam int ADDR_W = CH_W + SLOT_W;
    localparam int DEPTH_RAM = 1 << ADDR_W;
    localparam int DIV_W  = 65;  // dividend magnitude bits incl. headroom
    localparam int DCNT_W = 7;

    // per-channel state
    logic [FILL_W-1:0] fill_reg [CHANNELS];
    logic [SLOT_W-1:0] wslot_reg [CHANNELS];
    logic [TS_W-1:0]   last_rx_reg [CHANNELS];
    logic [CHANNELS-1:0] ever_reg, link_reg;
    logic [CNT_W-1:0]  used_cnt_reg [CHANNELS];
    logic [CNT_W-1:0]  disc_cnt_reg [CHANNELS];
    logic [CNT_W-1:0]  tol_cnt_reg [CHANNELS];
    logic [TS_W-1:0]   peak_reg [CHANNELS];
    logic [MEAN_W-1:0] mean_reg [CHANNELS];
    logic [TS_W-1:0]   ref_rx_reg;
    logic              ref_ever_reg;

    // match context
    logic [TS_W-1:0]   ts_reg, now_reg;
    logic              ref_ok_reg;
    logic              active_reg;
    logic [FILL_W-1:0] scan_fill_reg, scan_i_reg;
    logic [SLOT_W-1:0] scan_start_reg;
    logic [TS_W-1:0]   best_reg, best_abs_reg;
    logic              used_reg;
    logic              neg_reg;
    logic [DIV_W-1:0]  rem_reg, quo_reg;
    logic [DCNT_W-1:0] dcnt_reg;
    logic [CNT_W-1:0]  n_reg;

    // effective depth, clipped to HISTORY_MAX
    logic [FILL_W-1:0] depth_eff;
    assign depth_eff = (32'(cfg_depth) > HISTORY_MAX) ? FILL_W'(HISTORY_MAX)
                                                      : FILL_W'(cfg_depth);

    function automatic logic stale_f(input logic [TS_W-1:0] now, input logic [TS_W-1:0] last,
                                     input logic [TS_W-1:0] tmo);
        return (now > last) && ((now - last) > tmo);
    endfunction

    // channel index from request, range-checked
    logic ch_ok;
    logic [CH_W-1:0] req_ch;
    assign ch_ok  = (32'(channel) < CHANNELS);
    assign req_ch = CH_W'(channel);

    // history RAM
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [TS_W-1:0]   ram_rdata;
    logic [SLOT_W-1:0] rd_slot;

    assign ram_we    = cmd.do_push && ch_ok;
    assign ram_waddr = {req_ch, wslot_reg[req_ch]};
    // start + i modulo HISTORY_MAX
    logic [SLOT_W:0] slot_sum;
    assign slot_sum  = {1'b0, scan_start_reg} + (SLOT_W+1)'(scan_i_reg);
    assign rd_slot   = (32'(slot_sum) >= HISTORY_MAX) ? SLOT_W'(32'(slot_sum) - HISTORY_MAX)
                                                      : SLOT_W'(slot_sum);
    assign ram_raddr = {ch_idx, rd_slot};

    // oldest stored slot: write slot minus fill, wrapped once
    logic [SLOT_W-1:0] oldest_slot;
    assign oldest_slot = (32'(wslot_reg[ch_idx]) >= 32'(fill_reg[ch_idx]))
                         ? SLOT_W'(32'(wslot_reg[ch_idx]) - 32'(fill_reg[ch_idx]))
                         : SLOT_W'(32'(wslot_reg[ch_idx]) + HISTORY_MAX
                                   - 32'(fill_reg[ch_idx]));

    mcftm_ram #(.WIDTH(TS_W), .DEPTH(DEPTH_RAM)) u_hist (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (frame_timestamp),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // nearest search compare
    logic [TS_W-1:0] cand_abs;
    assign cand_abs = (ram_rdata >= ts_reg) ? ram_rdata - ts_reg : ts_reg - ram_rdata;

    // status for the current channel (combinational from latched values)
    logic [TS_W-1:0] abs_best;
    assign abs_best = best_abs_reg;

    assign stat.active    = active_reg;
    assign stat.used      = (abs_best <= cfg_tol);
    assign stat.scan_last = (scan_i_reg == scan_fill_reg - 1'b1);
    assign stat.div_last  = (dcnt_reg == '0);

    // mean update operands
    logic [MEAN_W-1:0] afx, cur_mean;
    logic [CNT_W-1:0]  n_next;
    assign afx      = {best_abs_reg, 16'h0};
    assign cur_mean = mean_reg[ch_idx];
    assign n_next   = (used_cnt_reg[ch_idx] == SAT32) ? SAT32 : used_cnt_reg[ch_idx] + 1'b1;

    // restoring division step: shift one dividend bit in per cycle
    logic [DIV_W:0]   trial;
    logic [DIV_W-1:0] rem_sh;
    assign rem_sh = {rem_reg[DIV_W-2:0], quo_reg[DIV_W-1]};
    assign trial  = {1'b0, rem_sh} - {{(DIV_W+1-CNT_W){1'b0}}, n_reg};

    logic [MEAN_W-1:0] quo64, mean_new;
    assign quo64    = quo_reg[MEAN_W-1:0];
    assign mean_new = neg_reg ? cur_mean - quo64 : cur_mean + quo64;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                fill_reg[c]     <= '0;
                wslot_reg[c]    <= '0;
                last_rx_reg[c]  <= '0;
                used_cnt_reg[c] <= '0;
                disc_cnt_reg[c] <= '0;
                tol_cnt_reg[c]  <= '0;
                peak_reg[c]     <= '0;
                mean_reg[c]     <= '0;
            end
            ever_reg     <= '0;
            link_reg     <= '1;
            ref_rx_reg   <= '0;
            ref_ever_reg <= 1'b0;
            result_valid <= 1'b0;
        end
        else
        begin
            result_valid <= cmd.commit;
            if (cmd.do_push && ch_ok)
            begin
                wslot_reg[req_ch]   <= (32'(wslot_reg[req_ch]) == HISTORY_MAX - 1) ? '0
                                       : wslot_reg[req_ch] + 1'b1;
                fill_reg[req_ch]    <= (({1'b0, fill_reg[req_ch]} + 1'b1) > {1'b0, depth_eff})
                                       ? depth_eff : fill_reg[req_ch] + 1'b1;
                last_rx_reg[req_ch] <= now_time;
                ever_reg[req_ch]    <= 1'b1;
            end
            if (cmd.do_ref)
            begin
                ref_rx_reg   <= now_time;
                ref_ever_reg <= 1'b1;
            end
            if (cmd.do_link && ch_ok)
            begin
                link_reg[req_ch] <= link_state;
            end
            if (cmd.upd)
            begin
                if (!active_reg)
                begin
                    disc_cnt_reg[ch_idx] <= (disc_cnt_reg[ch_idx] == SAT32) ? SAT32
                                            : disc_cnt_reg[ch_idx] + 1'b1;
                end
                else if (!stat.used)
                begin
                    tol_cnt_reg[ch_idx] <= (tol_cnt_reg[ch_idx] == SAT32) ? SAT32
                                           : tol_cnt_reg[ch_idx] + 1'b1;
                end
                else
                begin
                    used_cnt_reg[ch_idx] <= n_next;
                    if (best_abs_reg > peak_reg[ch_idx])
                    begin
                        peak_reg[ch_idx] <= best_abs_reg;
                    end
                end
            end
            if (cmd.commit && used_reg)
            begin
                mean_reg[ch_idx] <= mean_new;
            end
        end
    end

    // match context and scan registers (payload, no reset)
    always_ff @(posedge clk)
    begin
        if (start && cmd == '0 && !cmd.ch_load)
        begin
            ts_reg     <= frame_timestamp;
            now_reg    <= now_time;
            ref_ok_reg <= ref_ever_reg && !stale_f(now_time, ref_rx_reg, cfg_stale);
        end
        if (cmd.ch_load)
        begin
            active_reg     <= link_reg[ch_idx] && ever_reg[ch_idx]
                              && !stale_f(now_reg, last_rx_reg[ch_idx], cfg_stale)
                              && (fill_reg[ch_idx] != '0);
            scan_fill_reg  <= fill_reg[ch_idx];
            scan_i_reg     <= '0;
            scan_start_reg <= oldest_slot;
            best_reg       <= '0;
            best_abs_reg   <= '0;
            used_reg       <= 1'b0;
        end
        if (cmd.scan_cmp)
        begin
            if (scan_i_reg == '0 || cand_abs < best_abs_reg)
            begin
                best_reg     <= ram_rdata;
                best_abs_reg <= cand_abs;
            end
            scan_i_reg <= scan_i_reg + 1'b1;
        end
        if (cmd.upd)
        begin
            used_reg <= active_reg && stat.used;
            neg_reg  <= afx < cur_mean;
            rem_reg  <= '0;
            quo_reg  <= DIV_W'((afx >= cur_mean) ? afx - cur_mean : cur_mean - afx);
            n_reg    <= n_next;
            dcnt_reg <= DCNT_W'(DIV_W - 1);
        end
        if (cmd.div_step)
        begin
            if (!trial[DIV_W])
            begin
                rem_reg <= trial[DIV_W-1:0];
                quo_reg <= {quo_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh;
                quo_reg <= {quo_reg[DIV_W-2:0], 1'b0};
            end
            dcnt_reg <= dcnt_reg - 1'b1;
        end
        if (cmd.commit)
        begin
            out_channel            <= 4'(ch_idx);
            channel_active         <= active_reg;
            match_used             <= used_reg;
            time_delta             <= active_reg ? $signed({1'b0, best_reg} - {1'b0, ts_reg})
                                                 : '0;
            chosen_stamp           <= active_reg ? best_reg : '0;
            matched_count          <= used_cnt_reg[ch_idx];
            disconnected_count     <= disc_cnt_reg[ch_idx];
            out_of_tolerance_count <= tol_cnt_reg[ch_idx];
            largest_abs_delta      <= peak_reg[ch_idx];
            mean_abs_delta         <= used_reg ? mean_new : cur_mean;
            reference_connected    <= ref_ok_reg;
            last_result            <= last_ch;
        end
    end

    a_div_only_used: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> used_reg)
        else $error("division without used match");
    a_scan_active: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_rd |-> active_reg && scan_fill_reg != '0)
        else $error("scan on inactive channel");
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(fill_reg[0]) <= HISTORY_MAX)
        else $error("fill exceeds history size");
endmodule : mcftm_dp
`default_nettype wire

// ----- hdl/multi_channel_frame_timestamp_matcher.sv -----
// Top level of the multi-channel frame timestamp matcher.
// Depends on mcftm_pkg, mcftm_ctrl, mcftm_dp and mcftm_ram.
//
// A transaction is accepted when start is high and busy is low. Push, reference
// and link transactions finish in the accept cycle and give no result. A match
// transaction walks channels 0..CHANNELS-1 and emits one result per channel,
// each present for one cycle with result_valid high; there is no back-pressure,
// the receiver must take every result. Per channel the controller passes a
// load state, then a history RAM read and a compare for each stored stamp (an
// inactive channel passes the read state once without a read), an update state,
// the serial mean division when the match is used, an emit state and, except
// after the last channel, an advance state. The length of a match is bounded
// by the serial mean division and the single read port of the history RAM.
// The final result shows in the first cycle with busy low.
// Configuration writes (cfg_we/cfg_index/cfg_data) take effect at the next edge.
`default_nettype none
module multi_channel_frame_timestamp_matcher
    import mcftm_pkg::*;
#(
    parameter int CHANNELS    = CHANNELS_DEF,
    parameter int HISTORY_MAX = HISTORY_MAX_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    output logic                        busy,
    input  wire logic [1:0]             req_type,
    input  wire logic [3:0]             channel,
    input  wire logic [TS_W-1:0]        frame_timestamp,
    input  wire logic [TS_W-1:0]        now_time,
    input  wire logic                   link_state,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    output logic                        result_valid,
    output logic [3:0]                  out_channel,
    output logic                        channel_active,
    output logic                        match_used,
    output logic signed [TS_W:0]        time_delta,
    output logic [TS_W-1:0]             chosen_stamp,
    output logic [CNT_W-1:0]            matched_count,
    output logic [CNT_W-1:0]            disconnected_count,
    output logic [CNT_W-1:0]            out_of_tolerance_count,
    output logic [TS_W-1:0]             largest_abs_delta,
    output logic [MEAN_W-1:0]           mean_abs_delta,
    output logic                        reference_connected,
    output logic                        last_result
);
    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // configuration registers
    logic [DEPTH_W-1:0] depth_reg;
    logic [TS_W-1:0]    stale_reg, tol_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg <= DEPTH_W'(8);
            stale_reg <= TS_W'(200000);
            tol_reg   <= TS_W'(5000);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_HISTORY_DEPTH:   depth_reg <= cfg_data[DEPTH_W-1:0];
                CFG_STALE_TIMEOUT:   stale_reg <= cfg_data;
                CFG_MATCH_TOLERANCE: tol_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    dp_cmd_t         cmd;
    dp_stat_t        stat;
    logic [CH_W-1:0] ch_idx;
    logic            last_ch;
    logic            accept;

    assign accept = start && !busy;

    mcftm_ctrl #(.CHANNELS(CHANNELS)) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (req_type),
        .busy     (busy),
        .cmd      (cmd),
        .stat     (stat),
        .ch_idx   (ch_idx),
        .last_ch  (last_ch)
    );

    mcftm_dp #(.CHANNELS(CHANNELS), .HISTORY_MAX(HISTORY_MAX)) u_dp (
        .clk                    (clk),
        .rst_n                  (rst_n),
        .cmd                    (cmd),
        .stat                   (stat),
        .ch_idx                 (ch_idx),
        .last_ch                (last_ch),
        .start                  (accept),
        .channel                (channel),
        .frame_timestamp        (frame_timestamp),
        .now_time               (now_time),
        .link_state             (link_state),
        .cfg_depth              (depth_reg),
        .cfg_stale              (stale_reg),
        .cfg_tol                (tol_reg),
        .result_valid           (result_valid),
        .out_channel            (out_channel),
        .channel_active         (channel_active),
        .match_used             (match_used),
        .time_delta             (time_delta),
        .chosen_stamp           (chosen_stamp),
        .matched_count          (matched_count),
        .disconnected_count     (disconnected_count),
        .out_of_tolerance_count (out_of_tolerance_count),
        .largest_abs_delta      (largest_abs_delta),
        .mean_abs_delta         (mean_abs_delta),
        .reference_connected    (reference_connected),
        .last_result            (last_result)
    );

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && last_result |-> !busy)
        else $error("busy after final result");
    a_no_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy))
        else $error("result without transaction");
    a_cfg_hold: assert property (@(posedge clk) disable iff (!rst_n)
        busy && !cfg_we |=> $stable(tol_reg))
        else $error("tolerance changed");
endmodule : multi_channel_frame_timestamp_matcher
`default_nettype wire
